### design/hashed_grain_pixel_filter_assert.svh
// Assertion macros for the grain filter.
// Each expects clk and rst in scope.
`ifndef HASHED_GRAIN_PIXEL_FILTER_ASSERT_SVH
`define HASHED_GRAIN_PIXEL_FILTER_ASSERT_SVH

// same-cycle implication
`define GHF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GHF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ghf_pkg.sv
package ghf_pkg;

  localparam int COORD_BITS = 16;
  localparam int AMT_BITS = 8;
  localparam int FRAME_BITS = 31;
  localparam int CH_BITS = 8;
  localparam int COV_BITS = 9;
  localparam int HASH_BITS = 32;
  localparam int REM_BITS = AMT_BITS + 1;

  localparam int BITS_PER_STAGE = 4;
  localparam int MOD_STAGES = HASH_BITS / BITS_PER_STAGE;

  localparam int IN_BITS = 2 * COORD_BITS + 3 * CH_BITS + COV_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * CH_BITS;

  localparam logic [HASH_BITS-1:0] MUL_X = 32'd73856093;
  localparam logic [HASH_BITS-1:0] MUL_Y = 32'd19349663;
  localparam logic [HASH_BITS-1:0] MUL_F = 32'd83492791;
  localparam logic [HASH_BITS-1:0] MIX_MUL = 32'h5bd1e995;
  localparam int MIX_SHIFT_A = 13;
  localparam int MIX_SHIFT_B = 15;

  localparam logic [COV_BITS-1:0] COV_FULL = 9'd256;
  localparam logic [CH_BITS-1:0] CH_MAX = 8'd255;

  localparam logic CFG_AMOUNT = 1'b0;
  localparam logic CFG_FRAME = 1'b1;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic [COV_BITS-1:0] cov;
  } pix_t;

endpackage

### design/ghf_hash.sv
module ghf_hash (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [ghf_pkg::COORD_BITS-1:0] x,
  input  logic [ghf_pkg::COORD_BITS-1:0] y,
  input  ghf_pkg::pix_t in_pix,
  input  logic [ghf_pkg::FRAME_BITS-1:0] frame,
  output logic out_valid,
  output logic [ghf_pkg::HASH_BITS-1:0] mixed,
  output ghf_pkg::pix_t out_pix
);
  import ghf_pkg::*;

  logic [HASH_BITS-1:0] prod_x, prod_y, prod_f;
  logic vld_a;
  pix_t pix_a;
  logic [HASH_BITS-1:0] h0, h1;

  // stage A: three coordinate products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= HASH_BITS'(HASH_BITS'(x) * MUL_X);
      prod_y <= HASH_BITS'(HASH_BITS'(y) * MUL_Y);
      prod_f <= HASH_BITS'(HASH_BITS'(frame) * MUL_F);
      pix_a <= in_pix;
    end
  end

  // stage B: fold, first xor-shift and mixing multiply
  always_comb begin
    h0 = prod_x ^ prod_y ^ prod_f;
    h1 = h0 ^ (h0 >> MIX_SHIFT_A);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mixed <= HASH_BITS'(h1 * MIX_MUL);
      out_pix <= pix_a;
    end
  end

endmodule

### design/ghf_mod.sv
module ghf_mod (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [ghf_pkg::HASH_BITS-1:0] mixed,
  input  ghf_pkg::pix_t in_pix,
  input  logic [ghf_pkg::AMT_BITS-1:0] amount,
  output logic out_valid,
  output logic [ghf_pkg::REM_BITS-1:0] rem,
  output ghf_pkg::pix_t out_pix
);
  import ghf_pkg::*;
  `include "hashed_grain_pixel_filter_assert.svh"

  logic [REM_BITS-1:0] span;
  logic [HASH_BITS-1:0] hash;
  logic [MOD_STAGES-1:0] vld_q;
  logic [REM_BITS-1:0] rem_q [MOD_STAGES];
  logic [HASH_BITS-1:0] h_q [MOD_STAGES];
  pix_t pix_q [MOD_STAGES];

  // restoring remainder, a few hash bits per stage
  function automatic logic [REM_BITS-1:0] rem_chunk(
    input logic [REM_BITS-1:0] r_in,
    input logic [BITS_PER_STAGE-1:0] bits,
    input logic [REM_BITS-1:0] dvs
  );
    logic [REM_BITS:0] r;
    r = {1'b0, r_in};
    for (int k = BITS_PER_STAGE - 1; k >= 0; k--) begin
      r = {r[REM_BITS-1:0], bits[k]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
      end
    end
    return r[REM_BITS-1:0];
  endfunction

  assign span = {amount, 1'b1};
  assign hash = mixed ^ (mixed >> MIX_SHIFT_B);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[MOD_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= rem_chunk('0, hash[HASH_BITS-1 -: BITS_PER_STAGE], span);
      h_q[0] <= hash << BITS_PER_STAGE;
      pix_q[0] <= in_pix;
      for (int i = 1; i < MOD_STAGES; i++) begin
        rem_q[i] <= rem_chunk(rem_q[i-1], h_q[i-1][HASH_BITS-1 -: BITS_PER_STAGE], span);
        h_q[i] <= h_q[i-1] << BITS_PER_STAGE;
        pix_q[i] <= pix_q[i-1];
      end
    end
  end

  assign out_valid = vld_q[MOD_STAGES-1];
  assign rem = rem_q[MOD_STAGES-1];
  assign out_pix = pix_q[MOD_STAGES-1];

  `GHF_ASSERT_NOW(a_rem_below_span, out_valid, rem < span, "remainder not below span")
  `GHF_ASSERT_NEXT(a_rem_held, !en, $stable(rem) && $stable(out_valid), "stalled remainder moved")

endmodule

### design/ghf_blend.sv
module ghf_blend (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [ghf_pkg::REM_BITS-1:0] rem,
  input  ghf_pkg::pix_t in_pix,
  input  logic [ghf_pkg::AMT_BITS-1:0] amount,
  output logic out_valid,
  output logic [ghf_pkg::CH_BITS-1:0] red,
  output logic [ghf_pkg::CH_BITS-1:0] green,
  output logic [ghf_pkg::CH_BITS-1:0] blue
);
  import ghf_pkg::*;
  `include "hashed_grain_pixel_filter_assert.svh"

  localparam int DIFF_BITS = CH_BITS + 1;
  localparam int DELTA_BITS = REM_BITS + 1;
  localparam int PROD_BITS = 2 * CH_BITS + 2;

  logic signed [DELTA_BITS-1:0] delta;
  logic [CH_BITS-1:0] ch_in [3];
  logic signed [DIFF_BITS-1:0] diff_next [3];
  logic [COV_BITS-1:0] cov_sat;

  logic vld_1, vld_2;
  logic signed [DIFF_BITS-1:0] diff_1 [3];
  logic [CH_BITS-1:0] ch_1 [3];
  logic [COV_BITS-1:0] cov_1;
  logic signed [PROD_BITS-1:0] prod_2 [3];
  logic [CH_BITS-1:0] ch_2 [3];

  function automatic logic signed [DIFF_BITS-1:0] grain_diff(
    input logic [CH_BITS-1:0] ch,
    input logic signed [DELTA_BITS-1:0] d
  );
    logic signed [DELTA_BITS-1:0] sum;
    logic [CH_BITS-1:0] g;
    sum = $signed(DELTA_BITS'(ch)) + d;
    if (sum < 0) begin
      g = '0;
    end else if (sum > $signed(DELTA_BITS'(CH_MAX))) begin
      g = CH_MAX;
    end else begin
      g = sum[CH_BITS-1:0];
    end
    return $signed({1'b0, g}) - $signed({1'b0, ch});
  endfunction

  assign ch_in[0] = in_pix.red;
  assign ch_in[1] = in_pix.green;
  assign ch_in[2] = in_pix.blue;

  always_comb begin
    delta = $signed({1'b0, rem}) - $signed(DELTA_BITS'(amount));
    cov_sat = (in_pix.cov > COV_FULL) ? COV_FULL : in_pix.cov;
    for (int c = 0; c < 3; c++) begin
      diff_next[c] = grain_diff(ch_in[c], delta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_1 <= 1'b0;
      vld_2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_1 <= in_valid;
      vld_2 <= vld_1;
      out_valid <= vld_2;
    end
  end

  // stage 1: saturated grain difference; stage 2: coverage product; stage 3: add back
  always_ff @(posedge clk) begin
    if (en) begin
      cov_1 <= cov_sat;
      for (int c = 0; c < 3; c++) begin
        diff_1[c] <= diff_next[c];
        ch_1[c] <= ch_in[c];
        prod_2[c] <= $signed(PROD_BITS'(diff_1[c])) * $signed(PROD_BITS'({1'b0, cov_1}));
        ch_2[c] <= ch_1[c];
      end
      red <= ch_2[0] + prod_2[0][2*CH_BITS-1:CH_BITS];
      green <= ch_2[1] + prod_2[1][2*CH_BITS-1:CH_BITS];
      blue <= ch_2[2] + prod_2[2][2*CH_BITS-1:CH_BITS];
    end
  end

  `GHF_ASSERT_NEXT(a_zero_cov_zero_prod, en && vld_1 && cov_1 == '0, prod_2[0] == '0 && prod_2[1] == '0 && prod_2[2] == '0, "zero coverage gave a product")
  `GHF_ASSERT_NEXT(a_full_cov_range, en && vld_1 && cov_1 == COV_FULL, prod_2[0][CH_BITS-1:0] == '0, "full coverage product not whole")

endmodule

### design/hashed_grain_pixel_filter.sv
// Spatial hash grain filter for a pixel stream.
// Input stream (s_axis): one pixel per request with its coordinates, red,
// green and blue bytes and a coverage value (0..255, 256 = full replace,
// larger values act as 256). Output stream (m_axis): the blended channels.
// Configuration: cfg_we with cfg_index 0 writes grain_amount (cfg_data[7:0]),
// index 1 writes frame_number (cfg_data[30:0]); write only while the block
// is empty.
// Pipeline: the hash multipliers, the remainder by 2*amount+1 (four hash
// bits per stage), then the blend. Throughput is one pixel per clock
// while m_axis_tready does not hold the pipeline.
// The whole pipeline advances together; when m_axis_tready is low with a
// result on the output, every stage holds and s_axis_tready drops, so
// nothing is lost or repeated. Empty stages fill while the output waits
// only once it has been taken.
// Synchronous reset clears all valid bits and both configuration registers.
module hashed_grain_pixel_filter (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pixel_x, pixel_y, red_in, green_in, blue_in, coverage, zero pad
  input  logic [ghf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // red_out, green_out, blue_out
  output logic [ghf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [ghf_pkg::FRAME_BITS-1:0] cfg_data
);
  import ghf_pkg::*;

  localparam int Y_LSB = COORD_BITS;
  localparam int R_LSB = 2 * COORD_BITS;
  localparam int G_LSB = R_LSB + CH_BITS;
  localparam int B_LSB = G_LSB + CH_BITS;
  localparam int C_LSB = B_LSB + CH_BITS;

  logic [AMT_BITS-1:0] grain_amount;
  logic [FRAME_BITS-1:0] frame_number;
  logic en;
  pix_t pix_in, pix_h, pix_m;
  logic vld_h, vld_m;
  logic [HASH_BITS-1:0] mixed;
  logic [REM_BITS-1:0] rem;
  logic [CH_BITS-1:0] red, green, blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      grain_amount <= '0;
      frame_number <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AMOUNT: grain_amount <= cfg_data[AMT_BITS-1:0];
        CFG_FRAME: frame_number <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign pix_in.red = s_axis_tdata[R_LSB +: CH_BITS];
  assign pix_in.green = s_axis_tdata[G_LSB +: CH_BITS];
  assign pix_in.blue = s_axis_tdata[B_LSB +: CH_BITS];
  assign pix_in.cov = s_axis_tdata[C_LSB +: COV_BITS];

  ghf_hash u_hash (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s_axis_tvalid),
    .x(s_axis_tdata[COORD_BITS-1:0]),
    .y(s_axis_tdata[Y_LSB +: COORD_BITS]),
    .in_pix(pix_in),
    .frame(frame_number),
    .out_valid(vld_h),
    .mixed(mixed),
    .out_pix(pix_h)
  );

  ghf_mod u_mod (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(vld_h),
    .mixed(mixed),
    .in_pix(pix_h),
    .amount(grain_amount),
    .out_valid(vld_m),
    .rem(rem),
    .out_pix(pix_m)
  );

  ghf_blend u_blend (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(vld_m),
    .rem(rem),
    .in_pix(pix_m),
    .amount(grain_amount),
    .out_valid(m_axis_tvalid),
    .red(red),
    .green(green),
    .blue(blue)
  );

  assign m_axis_tdata = {blue, green, red};

endmodule

### bench/tb_top.sv
class grain_scoreboard;
  localparam bit [31:0] HASH_MUL_X = 32'd73856093;
  localparam bit [31:0] HASH_MUL_Y = 32'd19349663;
  localparam bit [31:0] HASH_MUL_F = 32'd83492791;
  localparam bit [31:0] HASH_MIX = 32'h5bd1e995;

  bit [7:0] amount;
  bit [30:0] frame;
  bit [23:0] expected_rgb[$];
  int mismatches;

  function new();
    amount = 0;
    frame = 0;
    mismatches = 0;
  endfunction

  function void set_register(logic idx, bit [30:0] value);
    if (idx == ghf_pkg::CFG_AMOUNT) amount = value[7:0];
    else frame = value;
  endfunction

  function int grain_offset(bit [15:0] x, bit [15:0] y);
    bit [31:0] h;
    bit [31:0] span;
    h = ({16'b0, x} * HASH_MUL_X) ^ ({16'b0, y} * HASH_MUL_Y) ^ ({1'b0, frame} * HASH_MUL_F);
    h = h ^ (h >> 13);
    h = h * HASH_MIX;
    h = h ^ (h >> 15);
    span = {23'b0, amount, 1'b1};
    return int'(h % span) - int'(amount);
  endfunction

  function bit [7:0] blend(bit [7:0] ch, int delta, int cov);
    int grained;
    int prod;
    int step;
    grained = int'(ch) + delta;
    if (grained < 0) grained = 0;
    if (grained > 255) grained = 255;
    prod = (grained - int'(ch)) * cov;
    step = prod >>> 8;
    return 8'(int'(ch) + step);
  endfunction

  function void note_pixel(logic [ghf_pkg::IN_TDATA_W-1:0] d);
    int cov;
    int delta;
    cov = int'(d[64:56]);
    if (cov > 256) cov = 256;
    delta = grain_offset(d[15:0], d[31:16]);
    expected_rgb.push_back({blend(d[55:48], delta, cov), blend(d[47:40], delta, cov),
                            blend(d[39:32], delta, cov)});
  endfunction

  function void check_pixel(logic [ghf_pkg::OUT_TDATA_W-1:0] got);
    bit [23:0] want;
    if (expected_rgb.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected pixel out: %h", got);
      return;
    end
    want = expected_rgb.pop_front();
    if (got[7:0] !== want[7:0] || got[15:8] !== want[15:8] || got[23:16] !== want[23:16]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel mismatch: red %0d/%0d green %0d/%0d blue %0d/%0d (exp/got)",
                 want[7:0], got[7:0], want[15:8], got[15:8], want[23:16], got[23:16]);
    end
  endfunction

  function int pending();
    return expected_rgb.size();
  endfunction
endclass

module tb_top;
  import ghf_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 272;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic cfg_index;
  logic [FRAME_BITS-1:0] cfg_data;

  grain_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_pending;
  int hold_left;
  int quiet_cycles;

  hashed_grain_pixel_filter dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_pixel(bit [15:0] x, bit [15:0] y, bit [7:0] r,
                                                       bit [7:0] g, bit [7:0] b, bit [8:0] cov);
    return {7'b0, cov, b, g, r, y, x};
  endfunction

  function automatic bit [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [7:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [8:0] rand_cov();
    case ($urandom_range(0, 9))
      0, 1: return 9'd0;
      2, 3: return COV_FULL;
      4: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 255));
    endcase
  endfunction

  // request offered at the falling edge, taken when tready is seen at the rising edge
  task automatic send_pixel(input logic [IN_TDATA_W-1:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(d);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input bit [30:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    bit [7:0] amounts[PHASES];
    bit [30:0] frames[PHASES];
    int idle_modes[4][2];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_AMOUNT;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_pending = 1'b0;
    quiet_cycles = 0;
    idle_modes = '{'{0, 0}, '{77, 0}, '{0, 77}, '{14, 14}};
    amounts = '{8'd255, 8'd1, 8'd0, 8'($urandom), 8'd128, 8'($urandom)};
    frames = '{31'h7fffffff, 31'd0, 31'd12345, 31'($urandom), 31'd1, 31'($urandom)};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero amount after reset: pass-through whatever the coverage
    send_pixel(pack_pixel(16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0, 9'd0));
    send_pixel(pack_pixel(16'hffff, 16'hffff, 8'd255, 8'd255, 8'd255, COV_FULL));
    send_pixel(pack_pixel(16'h1234, 16'h8001, 8'd123, 8'd45, 8'd200, 9'd511));
    wait_drained();

    write_register(CFG_AMOUNT, 31'd255);
    write_register(CFG_FRAME, 31'h7fffffff);
    send_pixel(pack_pixel(16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0, COV_FULL));
    send_pixel(pack_pixel(16'hffff, 16'hffff, 8'd255, 8'd255, 8'd255, COV_FULL));
    send_pixel(pack_pixel(16'h00ff, 16'hff00, 8'd10, 8'd128, 8'd250, 9'd0));
    send_pixel(pack_pixel(16'h0001, 16'h0000, 8'd128, 8'd128, 8'd128, 9'd255));
    send_pixel(pack_pixel(16'h0002, 16'h0000, 8'd0, 8'd128, 8'd255, 9'd1));
    send_pixel(pack_pixel(16'h0003, 16'h0000, 8'd0, 8'd128, 8'd255, 9'd257));
    send_pixel(pack_pixel(16'h0004, 16'h0000, 8'd255, 8'd0, 8'd128, 9'd511));
    send_pixel(pack_pixel(16'h0000, 16'h0001, 8'd0, 8'd128, 8'd255, COV_FULL));
    send_pixel(pack_pixel(16'h0000, 16'h0002, 8'd255, 8'd255, 8'd0, 9'd128));
    send_pixel(pack_pixel(16'h8000, 16'h8000, 8'd1, 8'd254, 8'd127, 9'd128));
    send_pixel(pack_pixel(16'h5555, 16'haaaa, 8'd200, 8'd20, 8'd100, 9'd64));
    send_pixel(pack_pixel(16'haaaa, 16'h5555, 8'd55, 8'd170, 8'd85, 9'd192));
    wait_drained();
    write_register(CFG_AMOUNT, 31'd1);
    send_pixel(pack_pixel(16'h0007, 16'h0009, 8'd0, 8'd255, 8'd128, COV_FULL));
    send_pixel(pack_pixel(16'hfffe, 16'h0003, 8'd255, 8'd0, 8'd1, COV_FULL));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = idle_modes[p % 4][0];
      recv_stall_pct = idle_modes[p % 4][1];
      write_register(CFG_AMOUNT, {23'b0, amounts[p]});
      write_register(CFG_FRAME, frames[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long output hold-off so the pipeline fills and backs up the input
        if (p == 0 && i == 40) hold_pending = 1'b1;
        // occasional bursts with no idling at all
        if (i % 64 == 32) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end else if (i % 64 == 48) begin
          send_idle_pct = idle_modes[p % 4][0];
          recv_stall_pct = idle_modes[p % 4][1];
        end
        send_pixel(pack_pixel(rand_coord(), rand_coord(), rand_channel(), rand_channel(),
                              rand_channel(), rand_cov()));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
